### rtl/tbs_pkg.sv
// Package of the target bearing sensor: default widths, register indexes and reset values.
// No dependencies; every other file of the block refers to it by scoped names.
package tbs_pkg;

    // Default position width and quaternion fraction bits.
    localparam int POS_WIDTH_DEF = 32;
    localparam int QUAT_FRAC_DEF = 14;

    // Configuration registers are all this wide.
    localparam int CFG_WIDTH = 32;
    localparam int CFG_IDX_W = 3;

    // Magnitudes are scaled down below this many bits before the square root.
    localparam int NORM_BITS = 30;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX    = 3'd4;

    // Reset values of the frame z bounds, -1.0 and +1.0 in Q16.16.
    localparam logic [CFG_WIDTH-1:0] Z_MIN_RST = 32'hFFFF_0000;
    localparam logic [CFG_WIDTH-1:0] Z_MAX_RST = 32'h0001_0000;

endpackage

### rtl/tbs_if.sv
// Channel interfaces of the target bearing sensor: sample input, result output and
// configuration writes. Depends on tbs_pkg for default widths.

// Sample channel: origin position, origin orientation and target position.
interface tbs_in_if #(
    parameter int POS_WIDTH  = tbs_pkg::POS_WIDTH_DEF,
    parameter int QUAT_WIDTH = tbs_pkg::QUAT_FRAC_DEF + 2
);
    logic                         valid;
    logic                         ready;
    logic signed [POS_WIDTH-1:0]  origin_x;
    logic signed [POS_WIDTH-1:0]  origin_y;
    logic signed [POS_WIDTH-1:0]  origin_z;
    logic signed [QUAT_WIDTH-1:0] orient_w;
    logic signed [QUAT_WIDTH-1:0] orient_x;
    logic signed [QUAT_WIDTH-1:0] orient_y;
    logic signed [QUAT_WIDTH-1:0] orient_z;
    logic signed [POS_WIDTH-1:0]  target_x;
    logic signed [POS_WIDTH-1:0]  target_y;
    logic signed [POS_WIDTH-1:0]  target_z;

    modport source (output valid, origin_x, origin_y, origin_z, orient_w, orient_x,
                    orient_y, orient_z, target_x, target_y, target_z, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, orient_w, orient_x,
                    orient_y, orient_z, target_x, target_y, target_z, output ready);
endinterface

// Result channel: bearing errors, visibility flag and saturated frame z.
interface tbs_out_if #(
    parameter int QUAT_WIDTH = tbs_pkg::QUAT_FRAC_DEF + 2
);
    logic                                  valid;
    logic                                  ready;
    logic signed [QUAT_WIDTH-1:0]          error_horizontal;
    logic signed [QUAT_WIDTH-1:0]          error_vertical;
    logic                                  out_of_sight;
    logic signed [tbs_pkg::CFG_WIDTH-1:0]  frame_z;

    modport source (output valid, error_horizontal, error_vertical, out_of_sight, frame_z,
                    input ready);
    modport sink   (input valid, error_horizontal, error_vertical, out_of_sight, frame_z,
                    output ready);
endinterface

// Configuration write channel: register index and write data.
interface tbs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tbs_pkg::CFG_IDX_W-1:0]      index;
    logic [tbs_pkg::CFG_WIDTH-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/target_bearing_sensor.sv
// Target bearing sensor: rotates the origin-to-target vector into the origin frame and
// reports bearing errors. Depends on tbs_pkg and the channel interfaces in tbs_if.

// One sample is accepted every clock unless the output stalls, and results leave in input
// order. The pipeline contains the fully pipelined 31-step integer square root and
// the QUAT_FRAC_BITS + 1 step restoring divider, one step per stage, run in two lanes for
// the horizontal and the vertical error. A stall at the output holds the whole pipeline,
// so the input is ready whenever the output register is empty or being taken.
// Configuration writes are always accepted and should be made only while no sample is
// in flight; there is no clearing pass after reset.
module target_bearing_sensor #(
    parameter int POS_WIDTH      = tbs_pkg::POS_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = tbs_pkg::QUAT_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbs_in_if.sink      i_in,
    tbs_out_if.source   o_out,
    tbs_cfg_if.sink     i_cfg
);

    localparam int F        = QUAT_FRAC_BITS;
    localparam int QW       = F + 2;
    localparam int CW       = tbs_pkg::CFG_WIDTH;
    localparam int D        = ((POS_WIDTH > CW) ? POS_WIDTH : CW) + 2;
    localparam int PQ       = 2 * QW;
    localparam int MRW      = PQ + 2;
    localparam int MW       = MRW - F;
    localparam int PW       = MW + D;
    localparam int SW       = PW + 2;
    localparam int FW       = SW - F;
    localparam int NB       = tbs_pkg::NORM_BITS;
    localparam int AXW      = (FW > NB) ? FW : NB;
    localparam int SHW      = $clog2(AXW + 1);
    localparam int LW       = (FW > CW) ? FW : CW;
    localparam int SQW      = 2 * NB + 2;
    localparam int RW       = NB + 1;
    localparam int SQ_STEPS = NB + 1;
    localparam int NW       = NB + F + 1;
    localparam int DV_STEPS = F + 1;
    localparam int QTW      = F + 1;
    localparam int LAT      = 9 + SQ_STEPS + DV_STEPS;

    localparam logic signed [MRW-1:0] HALF_M = MRW'(1) << (F - 1);
    localparam logic signed [SW-1:0]  HALF_S = SW'(1) << (F - 1);

    // Indexes of the quaternion products.
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_WX = 4;
    localparam int P_WY = 5;
    localparam int P_WZ = 6;
    localparam int P_XY = 7;
    localparam int P_XZ = 8;
    localparam int P_YZ = 9;

    // Per-sample data that rides along the square root and divider stages.
    typedef struct packed {
        logic                hid;
        logic [1:0]          neg;
        logic [1:0][NB-1:0]  a;
        logic [CW-1:0]       fzs;
    } t_side;

    // Configuration registers.
    logic signed [CW-1:0] r_off [3];
    logic signed [CW-1:0] r_z_min;
    logic signed [CW-1:0] r_z_max;

    // Pipeline control.
    logic [LAT-1:0] r_vld;
    logic           advance;

    // Stage A: difference vector and quaternion products.
    logic signed [D-1:0]  r_a_d [3];
    logic signed [PQ-1:0] r_a_p [10];
    logic signed [D-1:0]  n_a_d [3];
    logic signed [PQ-1:0] n_a_p [10];
    // Stage B: rounded rotation matrix.
    logic signed [D-1:0]  r_b_d [3];
    logic signed [MW-1:0] r_b_m [9];
    logic signed [MW-1:0] n_b_m [9];
    // Stage C: matrix times vector products.
    logic signed [PW-1:0] r_c_p [9];
    logic signed [PW-1:0] n_c_p [9];
    // Stage D: rounded frame vector.
    logic signed [FW-1:0] r_d_f [3];
    logic signed [FW-1:0] n_d_f [3];
    // Stage E: scaled magnitudes and saturated frame z.
    logic [NB-1:0] r_e_z [2];
    logic [NB-1:0] n_e_z [2];
    t_side         r_e_side;
    t_side         n_e_side;
    // Stage F: squares.
    logic [2*NB-1:0] r_f_sq [2][2];
    logic [2*NB-1:0] n_f_sq [2][2];
    t_side           r_f_side;
    // Square root stages; entry zero holds the sum of squares.
    logic [SQW-1:0] r_sn [2][0:SQ_STEPS];
    logic [SQW-1:0] r_sr [2][0:SQ_STEPS];
    logic [SQW-1:0] n_sn [2][0:SQ_STEPS];
    logic [SQW-1:0] n_sr [2][0:SQ_STEPS];
    t_side          r_sq_side [0:SQ_STEPS];
    t_side          n_sq_side [0:SQ_STEPS];
    // Divider stages; entry zero holds the numerator and divisor.
    logic [NW-1:0]  r_rem [2][0:DV_STEPS];
    logic [QTW-1:0] r_quo [2][0:DV_STEPS];
    logic [RW-1:0]  r_dvr [2][0:DV_STEPS];
    logic [NW-1:0]  n_rem [2][0:DV_STEPS];
    logic [QTW-1:0] n_quo [2][0:DV_STEPS];
    logic [RW-1:0]  n_dvr [2][0:DV_STEPS];
    t_side          r_dv_side [0:DV_STEPS];
    t_side          n_dv_side [0:DV_STEPS];
    // Output register.
    logic signed [QW-1:0] r_o_e [2];
    logic signed [QW-1:0] n_o_e [2];
    logic                 r_o_hid;
    logic [CW-1:0]        r_o_fz;

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance     = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = advance;
    assign i_cfg.ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
            r_z_min  <= tbs_pkg::Z_MIN_RST;
            r_z_max  <= tbs_pkg::Z_MAX_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tbs_pkg::CFG_OFFSET_X: r_off[0] <= i_cfg.data;
                tbs_pkg::CFG_OFFSET_Y: r_off[1] <= i_cfg.data;
                tbs_pkg::CFG_OFFSET_Z: r_off[2] <= i_cfg.data;
                tbs_pkg::CFG_Z_MIN:    r_z_min  <= i_cfg.data;
                tbs_pkg::CFG_Z_MAX:    r_z_max  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage A: offset origin, difference vector and the ten quaternion products.
    always_comb begin
        logic signed [QW-1:0] q [4];
        q[0] = i_in.orient_w;
        q[1] = i_in.orient_x;
        q[2] = i_in.orient_y;
        q[3] = i_in.orient_z;
        n_a_d[0] = D'(i_in.target_x) - (D'(i_in.origin_x) + D'(r_off[0]));
        n_a_d[1] = D'(i_in.target_y) - (D'(i_in.origin_y) + D'(r_off[1]));
        n_a_d[2] = D'(i_in.target_z) - (D'(i_in.origin_z) + D'(r_off[2]));
        n_a_p[P_WW] = PQ'(q[0]) * PQ'(q[0]);
        n_a_p[P_XX] = PQ'(q[1]) * PQ'(q[1]);
        n_a_p[P_YY] = PQ'(q[2]) * PQ'(q[2]);
        n_a_p[P_ZZ] = PQ'(q[3]) * PQ'(q[3]);
        n_a_p[P_WX] = PQ'(q[0]) * PQ'(q[1]);
        n_a_p[P_WY] = PQ'(q[0]) * PQ'(q[2]);
        n_a_p[P_WZ] = PQ'(q[0]) * PQ'(q[3]);
        n_a_p[P_XY] = PQ'(q[1]) * PQ'(q[2]);
        n_a_p[P_XZ] = PQ'(q[1]) * PQ'(q[3]);
        n_a_p[P_YZ] = PQ'(q[2]) * PQ'(q[3]);
    end

    // Stage B: rotation matrix entries, rounded back to the quaternion fraction.
    always_comb begin
        logic signed [MRW-1:0] mr [9];
        logic signed [MRW-1:0] t;
        mr[0] = MRW'(r_a_p[P_WW]) + MRW'(r_a_p[P_XX]) - MRW'(r_a_p[P_YY]) - MRW'(r_a_p[P_ZZ]);
        mr[1] = (MRW'(r_a_p[P_XY]) + MRW'(r_a_p[P_WZ])) <<< 1;
        mr[2] = (MRW'(r_a_p[P_XZ]) - MRW'(r_a_p[P_WY])) <<< 1;
        mr[3] = (MRW'(r_a_p[P_XY]) - MRW'(r_a_p[P_WZ])) <<< 1;
        mr[4] = MRW'(r_a_p[P_WW]) + MRW'(r_a_p[P_YY]) - MRW'(r_a_p[P_XX]) - MRW'(r_a_p[P_ZZ]);
        mr[5] = (MRW'(r_a_p[P_YZ]) + MRW'(r_a_p[P_WX])) <<< 1;
        mr[6] = (MRW'(r_a_p[P_XZ]) + MRW'(r_a_p[P_WY])) <<< 1;
        mr[7] = (MRW'(r_a_p[P_YZ]) - MRW'(r_a_p[P_WX])) <<< 1;
        mr[8] = MRW'(r_a_p[P_WW]) + MRW'(r_a_p[P_ZZ]) - MRW'(r_a_p[P_XX]) - MRW'(r_a_p[P_YY]);
        for (int i = 0; i < 9; i++) begin
            t = (mr[i] + HALF_M) >>> F;
            n_b_m[i] = t[MW-1:0];
        end
    end

    // Stage C: the nine products of matrix entry and vector component.
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            n_c_p[i] = PW'(r_b_m[i]) * PW'(r_b_d[i % 3]);
        end
    end

    // Stage D: row sums rounded back to Q16.16.
    always_comb begin
        logic signed [SW-1:0] s;
        for (int r = 0; r < 3; r++) begin
            s = (SW'(r_c_p[3*r]) + SW'(r_c_p[3*r+1]) + SW'(r_c_p[3*r+2]) + HALF_S) >>> F;
            n_d_f[r] = s[FW-1:0];
        end
    end

    // Stage E: visibility, magnitudes scaled below the square root range, and clamping.
    always_comb begin
        logic [FW-1:0]  mag;
        logic [AXW-1:0] ax;
        logic [AXW-1:0] zx;
        logic [AXW-1:0] orv;
        logic [AXW-1:0] as;
        logic [AXW-1:0] zs;
        logic [SHW-1:0] sh;
        logic signed [LW-1:0] fl;
        n_e_side.hid = (r_d_f[2] <= 0);
        zx = AXW'(FW'(r_d_f[2]));
        for (int l = 0; l < 2; l++) begin
            n_e_side.neg[l] = r_d_f[l][FW-1];
            mag = r_d_f[l][FW-1] ? FW'(-r_d_f[l]) : FW'(r_d_f[l]);
            ax  = AXW'(mag);
            orv = ax | zx;
            sh  = '0;
            for (int i = NB; i < AXW; i++) begin
                if (orv[i]) begin
                    sh = SHW'(i - NB + 1);
                end
            end
            as = ax >> sh;
            zs = zx >> sh;
            n_e_side.a[l] = as[NB-1:0];
            n_e_z[l]      = zs[NB-1:0];
        end
        // Raise to the lower bound first, then lower to the upper bound.
        fl = LW'(r_d_f[2]);
        if (fl < LW'(r_z_min)) begin
            fl = LW'(r_z_min);
        end
        if (fl > LW'(r_z_max)) begin
            fl = LW'(r_z_max);
        end
        n_e_side.fzs = fl[CW-1:0];
    end

    // Stage F: squares of the scaled magnitudes.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_f_sq[l][0] = (2*NB)'(r_e_side.a[l]) * (2*NB)'(r_e_side.a[l]);
            n_f_sq[l][1] = (2*NB)'(r_e_z[l]) * (2*NB)'(r_e_z[l]);
        end
    end

    // Sum of squares, then one square root step per stage.
    always_comb begin
        logic [SQW-1:0] bitv;
        logic [SQW-1:0] t;
        n_sq_side[0] = r_f_side;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            n_sq_side[k] = r_sq_side[k-1];
        end
        for (int l = 0; l < 2; l++) begin
            n_sn[l][0] = SQW'(r_f_sq[l][0]) + SQW'(r_f_sq[l][1]);
            n_sr[l][0] = '0;
            for (int k = 0; k < SQ_STEPS; k++) begin
                bitv = SQW'(1) << (2*NB - 2*k);
                t    = r_sr[l][k] + bitv;
                if (r_sn[l][k] >= t) begin
                    n_sn[l][k+1] = r_sn[l][k] - t;
                    n_sr[l][k+1] = (r_sr[l][k] >> 1) + bitv;
                end else begin
                    n_sn[l][k+1] = r_sn[l][k];
                    n_sr[l][k+1] = r_sr[l][k] >> 1;
                end
            end
        end
    end

    // Rounded numerator, then one restoring division step per stage.
    always_comb begin
        logic [RW-1:0] rt;
        logic [NW-1:0] ds;
        n_dv_side[0] = r_sq_side[SQ_STEPS];
        for (int j = 1; j <= DV_STEPS; j++) begin
            n_dv_side[j] = r_dv_side[j-1];
        end
        for (int l = 0; l < 2; l++) begin
            rt = r_sr[l][SQ_STEPS][RW-1:0];
            n_rem[l][0] = (NW'(r_sq_side[SQ_STEPS].a[l]) << F) + NW'(rt >> 1);
            n_quo[l][0] = '0;
            n_dvr[l][0] = rt;
            for (int j = 0; j < DV_STEPS; j++) begin
                ds = NW'(r_dvr[l][j]) << (F - j);
                n_dvr[l][j+1] = r_dvr[l][j];
                if (r_rem[l][j] >= ds) begin
                    n_rem[l][j+1] = r_rem[l][j] - ds;
                    n_quo[l][j+1] = r_quo[l][j] | (QTW'(1) << (F - j));
                end else begin
                    n_rem[l][j+1] = r_rem[l][j];
                    n_quo[l][j+1] = r_quo[l][j];
                end
            end
        end
    end

    // Output: apply the sign, or force zero when the target is out of sight or the root is zero.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (r_dv_side[DV_STEPS].hid || (r_dvr[l][DV_STEPS] == '0)) begin
                n_o_e[l] = '0;
            end else if (r_dv_side[DV_STEPS].neg[l]) begin
                n_o_e[l] = -QW'(r_quo[l][DV_STEPS]);
            end else begin
                n_o_e[l] = QW'(r_quo[l][DV_STEPS]);
            end
        end
    end

    // Valid bits travel with the samples.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_d     <= n_a_d;
            r_a_p     <= n_a_p;
            r_b_d     <= r_a_d;
            r_b_m     <= n_b_m;
            r_c_p     <= n_c_p;
            r_d_f     <= n_d_f;
            r_e_z     <= n_e_z;
            r_e_side  <= n_e_side;
            r_f_sq    <= n_f_sq;
            r_f_side  <= r_e_side;
            r_sn      <= n_sn;
            r_sr      <= n_sr;
            r_sq_side <= n_sq_side;
            r_rem     <= n_rem;
            r_quo     <= n_quo;
            r_dvr     <= n_dvr;
            r_dv_side <= n_dv_side;
            r_o_e     <= n_o_e;
            r_o_hid   <= r_dv_side[DV_STEPS].hid;
            r_o_fz    <= r_dv_side[DV_STEPS].fzs;
        end
    end

    assign o_out.valid            = r_vld[LAT-1];
    assign o_out.error_horizontal = r_o_e[0];
    assign o_out.error_vertical   = r_o_e[1];
    assign o_out.out_of_sight     = r_o_hid;
    assign o_out.frame_z          = r_o_fz;

    // A hidden target always reports zero errors.
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.out_of_sight |->
            (o_out.error_horizontal == '0) && (o_out.error_vertical == '0))
        else $error("out of sight result with non-zero error");

    // The divider never produces a bearing beyond unity.
    a_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            (o_out.error_horizontal <= $signed(QW'(1) << F)) &&
            (o_out.error_horizontal >= -$signed(QW'(1) << F)) &&
            (o_out.error_vertical <= $signed(QW'(1) << F)) &&
            (o_out.error_vertical >= -$signed(QW'(1) << F)))
        else $error("bearing error beyond unity");

    // An accepted beat enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");

endmodule

### tb/tb_target_bearing_sensor.sv
// Self-checking testbench of the target bearing sensor: a directed table, then random samples.
// Results are checked against a bit-exact predictor, or against hand-read values for typed rows.
// Depends on tbs_pkg, the tbs_if channels and the RTL.
module tb_target_bearing_sensor;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] origin_x, origin_y, origin_z;
        logic signed [15:0] orient_w, orient_x, orient_y, orient_z;
        logic signed [31:0] target_x, target_y, target_z;
    } t_sample;

    typedef struct {
        logic signed [15:0] err_h;
        logic signed [15:0] err_v;
        logic               hidden;
        logic signed [31:0] frame_z;
    } t_bearing;

    typedef struct {
        t_sample  smp;
        bit       typed;
        t_bearing res;
    } t_row;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 70;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tbs_in_if  in_ch ();
    tbs_out_if out_ch ();
    tbs_cfg_if cfg_ch ();

    target_bearing_sensor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #4 i_clk = ~i_clk;

    // Predictor's own copy of the registers.
    logic signed [31:0] off_x, off_y, off_z, zlo, zhi;

    t_bearing pending_q[$];
    int       fail_count = 0;
    bit       hold_req = 0;
    t_row     directed[$];

    // Integer square root, floor.
    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // a / sqrt(a^2 + z^2) in Q1.14, z positive.
    function automatic longint bearing_err(longint a, longint z);
        longint unsigned ua, uz, r, e;
        bit neg;
        neg = a < 0;
        ua = neg ? longint'(-a) : a;
        uz = z;
        while (((ua | uz) >> tbs_pkg::NORM_BITS) != 0) begin
            ua = ua >> 1;
            uz = uz >> 1;
        end
        r = isqrt(ua * ua + uz * uz);
        if (r == 0) return 0;
        e = ((ua << 14) + r / 2) / r;
        return neg ? -longint'(e) : longint'(e);
    endfunction

    function automatic longint rnd14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    // Rotation into the origin frame and bearing of the target.
    function automatic t_bearing predict_bearing(t_sample s);
        longint dx, dy, dz, w, x, y, z, fx, fy, fz, fzs;
        longint m[9];
        t_bearing r;
        dx = longint'(s.target_x) - (longint'(s.origin_x) + longint'(off_x));
        dy = longint'(s.target_y) - (longint'(s.origin_y) + longint'(off_y));
        dz = longint'(s.target_z) - (longint'(s.origin_z) + longint'(off_z));
        w = longint'(s.orient_w); x = longint'(s.orient_x);
        y = longint'(s.orient_y); z = longint'(s.orient_z);
        m[0] = w*w + x*x - y*y - z*z;
        m[1] = 2 * (x*y + w*z);
        m[2] = 2 * (x*z - w*y);
        m[3] = 2 * (x*y - w*z);
        m[4] = w*w + y*y - x*x - z*z;
        m[5] = 2 * (y*z + w*x);
        m[6] = 2 * (x*z + w*y);
        m[7] = 2 * (y*z - w*x);
        m[8] = w*w + z*z - x*x - y*y;
        foreach (m[i]) m[i] = rnd14(m[i]);
        fx = rnd14(m[0]*dx + m[1]*dy + m[2]*dz);
        fy = rnd14(m[3]*dx + m[4]*dy + m[5]*dz);
        fz = rnd14(m[6]*dx + m[7]*dy + m[8]*dz);
        r.hidden = !(fz > 0);
        r.err_h = r.hidden ? 16'sd0 : 16'(bearing_err(fx, fz));
        r.err_v = r.hidden ? 16'sd0 : 16'(bearing_err(fy, fz));
        fzs = fz;
        if (fzs < longint'(zlo)) fzs = longint'(zlo);
        if (fzs > longint'(zhi)) fzs = longint'(zhi);
        r.frame_z = 32'(fzs);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Result monitor: each beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_bearing want;
        if (out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_q.pop_front();
                if (out_ch.error_horizontal !== want.err_h)
                    report_mismatch("error_horizontal", out_ch.error_horizontal, want.err_h);
                if (out_ch.error_vertical !== want.err_v)
                    report_mismatch("error_vertical", out_ch.error_vertical, want.err_v);
                if (out_ch.out_of_sight !== want.hidden)
                    report_mismatch("out_of_sight", out_ch.out_of_sight, want.hidden);
                if (out_ch.frame_z !== want.frame_z)
                    report_mismatch("frame_z", out_ch.frame_z, want.frame_z);
            end
        end
    end

    // Result receiver: random stalls, with one long hold-off on request.
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                gap = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) gap = 0;
                if (hold_req) begin
                    hold_req = 0;
                    gap = HOLD_OFF_CYCLES;
                end
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Offer one sample and wait for its beat; the expectation is formed on acceptance.
    task automatic send_sample(t_sample s, bit typed, t_bearing res);
        int gap;
        in_ch.valid    <= 1'b1;
        in_ch.origin_x <= s.origin_x;
        in_ch.origin_y <= s.origin_y;
        in_ch.origin_z <= s.origin_z;
        in_ch.orient_w <= s.orient_w;
        in_ch.orient_x <= s.orient_x;
        in_ch.orient_y <= s.orient_y;
        in_ch.orient_z <= s.orient_z;
        in_ch.target_x <= s.target_x;
        in_ch.target_y <= s.target_y;
        in_ch.target_z <= s.target_z;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_q.push_back(typed ? res : predict_bearing(s));
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [tbs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            tbs_pkg::CFG_OFFSET_X: off_x = data;
            tbs_pkg::CFG_OFFSET_Y: off_y = data;
            tbs_pkg::CFG_OFFSET_Z: off_z = data;
            tbs_pkg::CFG_Z_MIN:    zlo = data;
            tbs_pkg::CFG_Z_MAX:    zhi = data;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [31:0] lo, logic [31:0] hi);
        write_reg(tbs_pkg::CFG_OFFSET_X, ox);
        write_reg(tbs_pkg::CFG_OFFSET_Y, oy);
        write_reg(tbs_pkg::CFG_OFFSET_Z, oz);
        write_reg(tbs_pkg::CFG_Z_MIN, lo);
        write_reg(tbs_pkg::CFG_Z_MAX, hi);
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender pause until every result has come, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_sample mk(longint ox, longint oy, longint oz, int qw, int qx,
                                   int qy, int qz, longint tx, longint ty, longint tz);
        t_sample s;
        s.origin_x = 32'(ox); s.origin_y = 32'(oy); s.origin_z = 32'(oz);
        s.orient_w = 16'(qw); s.orient_x = 16'(qx); s.orient_y = 16'(qy);
        s.orient_z = 16'(qz);
        s.target_x = 32'(tx); s.target_y = 32'(ty); s.target_z = 32'(tz);
        return s;
    endfunction

    function automatic t_row row(t_sample s, bit typed, int eh, int ev, bit hid, longint fz);
        t_row r;
        r.smp = s;
        r.typed = typed;
        r.res.err_h = 16'(eh); r.res.err_v = 16'(ev); r.res.hidden = hid;
        r.res.frame_z = 32'(fz);
        return r;
    endfunction

    // Random position: mostly a few units, sometimes the full range.
    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
    endfunction

    function automatic logic [15:0] rand_quat_part();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'(11585 * (($urandom_range(0, 1) == 1) ? 1 : -1));
            4: return 16'sd0;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        s.origin_x = rand_pos(); s.origin_y = rand_pos(); s.origin_z = rand_pos();
        s.target_x = rand_pos(); s.target_y = rand_pos(); s.target_z = rand_pos();
        s.orient_w = rand_quat_part(); s.orient_x = rand_quat_part();
        s.orient_y = rand_quat_part(); s.orient_z = rand_quat_part();
        // Keep many orientations pure rotations about one axis.
        if ($urandom_range(0, 2) == 0) begin
            s.orient_y = '0;
            s.orient_z = '0;
        end
        return s;
    endfunction

    // Run-time limit.
    initial begin
        #4ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_bearing none;
        none = '{default: '0};
        in_ch.valid <= 1'b0;
        in_ch.origin_x <= '0; in_ch.origin_y <= '0; in_ch.origin_z <= '0;
        in_ch.orient_w <= '0; in_ch.orient_x <= '0; in_ch.orient_y <= '0;
        in_ch.orient_z <= '0;
        in_ch.target_x <= '0; in_ch.target_y <= '0; in_ch.target_z <= '0;
        cfg_ch.valid <= 1'b0; cfg_ch.index <= '0; cfg_ch.data <= '0;
        off_x = '0; off_y = '0; off_z = '0;
        zlo = tbs_pkg::Z_MIN_RST; zhi = tbs_pkg::Z_MAX_RST;

        // Directed rows; the first few with results read off by hand.
        directed.push_back(row(mk(0, 0, 0, 16384, 0, 0, 0, 0, 0, 65536), 1, 0, 0, 0, 65536));
        directed.push_back(row(mk(0, 0, 0, 16384, 0, 0, 0, 0, 0, -65536), 1, 0, 0, 1, -65536));
        directed.push_back(row(mk(0, 0, 0, 16384, 0, 0, 0, 65536, 65536, 65536),
                               1, 11585, 11585, 0, 65536));
        directed.push_back(row(mk(0, 0, 0, 16384, 0, 0, 0, -65536, -65536, 65536),
                               1, -11585, -11585, 0, 65536));
        directed.push_back(row(mk(5, 6, 7, 16384, 0, 0, 0, 5, 6, 7), 1, 0, 0, 1, 0));
        directed.push_back(row(mk(-2147483648, -2147483648, -2147483648, 16384, 0, 0, 0,
                                  2147483647, 2147483647, 2147483647), 0, 0, 0, 0, 0));
        directed.push_back(row(mk(2147483647, 2147483647, 2147483647, 16384, 0, 0, 0,
                                  -2147483648, -2147483648, -2147483648), 0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, 0, 16384, 0, 0, 65536, 65536, -65536),
                               0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, 11585, 0, 11585, 0, 131072, 0, 65536),
                               0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, -32768, -32768, -32768, -32768, 100, 200, 300),
                               0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, 32767, 32767, 32767, 32767, -300, 200, 900000),
                               0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, 16384, 16384, 0, 0, 1000, -1000, 4000),
                               0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, 16384, 0, 0, 0, 0, 2147483647, 1), 0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, 16384, 0, 0, 0, 1, 0, 2147483647), 0, 0, 0, 0, 0));
        directed.push_back(row(mk(0, 0, 0, -16384, 0, 0, 16384, 70000, -9, 12345),
                               0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values first, then every register written.
        foreach (directed[i]) send_sample(directed[i].smp, directed[i].typed, directed[i].res);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_all('0, '0, '0, tbs_pkg::Z_MIN_RST, tbs_pkg::Z_MAX_RST);
                1: write_all(rand_pos(), rand_pos(), rand_pos(), 32'h8000_0000, 32'h7FFF_FFFF);
                2: write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0000_4000, 32'hFFFF_C000);
                default: write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            @(posedge i_clk);
            for (int n = 0; n < 135; n++) begin
                if (phase == 1 && n == 20) hold_req = 1;
                send_sample(rand_sample(), 0, none);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
